>>> rtl/core/bpra_pkg.sv
`default_nettype none

package bpra_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BATTERY_COUNT  = 2'd0,
        REG_VOLTAGE_OFFSET = 2'd1,
        REG_VOLTAGE_SCALE  = 2'd2,
        REG_WINDOW_SIZE    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_WRITE,
        ST_SUM,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_VOLTAGE,
        SEL_CURRENT,
        SEL_POWER
    } mean_sel_t;

    localparam int unsigned ROW_W = 3;
    localparam int unsigned ROWS  = 8;

    // current channel calibration, Q1.13 offsets and Q6.16 gain
    localparam logic [13:0] CAL_OFFSET_DEFAULT = 14'd2650;
    localparam logic [13:0] CAL_OFFSET_FOUR    = 14'd13238;
    localparam logic [21:0] CAL_GAIN           = 22'd2482425;

    localparam logic [13:0] CAL_OFFSET_ROM [ROWS] = '{
        CAL_OFFSET_DEFAULT, CAL_OFFSET_DEFAULT, CAL_OFFSET_DEFAULT, CAL_OFFSET_FOUR,
        CAL_OFFSET_DEFAULT, CAL_OFFSET_DEFAULT, CAL_OFFSET_DEFAULT, CAL_OFFSET_DEFAULT
    };
    localparam logic [21:0] CAL_GAIN_ROM [ROWS] = '{
        CAL_GAIN, CAL_GAIN, CAL_GAIN, CAL_GAIN, CAL_GAIN, CAL_GAIN, CAL_GAIN, CAL_GAIN
    };

    localparam logic [3:0]  BATTERY_COUNT_RESET  = 4'd4;
    localparam logic [23:0] VOLTAGE_SCALE_RESET  = 24'd65536;
    localparam logic [6:0]  WINDOW_SIZE_RESET    = 7'd10;

    localparam int unsigned ADC_FRAC   = 13;
    localparam int unsigned RESULT_FRAC = 16;

    // battery counts outside one to eight fall back to row four
    function automatic logic [ROW_W-1:0] cal_row(input logic [3:0] count);
        logic [3:0] row;
        row = count - 4'd1;
        if (count >= 4'd1 && count <= 4'd8) begin
            cal_row = row[ROW_W-1:0];
        end
        else begin
            cal_row = ROW_W'(3);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bpra_ifs.sv
`default_nettype none

interface bpra_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] current_sense;
    logic [15:0] voltage_sense;

    modport source (output valid, output current_sense, output voltage_sense, input ready);
    modport sink (input valid, input current_sense, input voltage_sense, output ready);
endinterface

interface bpra_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] latest_current;
    logic signed [31:0] latest_voltage;
    logic signed [31:0] mean_voltage;
    logic signed [31:0] mean_current;
    logic signed [31:0] mean_power;

    modport source (output valid, output latest_current, output latest_voltage,
                    output mean_voltage, output mean_current, output mean_power,
                    input ready);
    modport sink (input valid, input latest_current, input latest_voltage,
                  input mean_voltage, input mean_current, input mean_power,
                  output ready);
endinterface

interface bpra_cfg_if;
    import bpra_pkg::*;
    logic        valid;
    logic        ready;
    cfg_index_t  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bpra_hist_mem.sv
`default_nettype none

module bpra_hist_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned W     = 96
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [W-1:0]  wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpra_calib.sv
`default_nettype none

module bpra_calib (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [15:0]        current_sense,
    input  wire logic [15:0]        voltage_sense,
    input  wire logic [3:0]         battery_count,
    input  wire logic signed [15:0] voltage_offset,
    input  wire logic [23:0]        voltage_scale,
    output logic                    done,
    output logic signed [31:0]      current,
    output logic signed [31:0]      voltage,
    output logic signed [31:0]      power
);
    import bpra_pkg::*;

    // divide by 2^s rounding toward zero
    function automatic logic signed [63:0] shift_trunc(input logic signed [63:0] v,
                                                       input int unsigned s);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< s) - 64'sd1) : 64'sd0;
        shift_trunc = (v + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            sat32 = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            sat32 = 32'sh8000_0000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

    logic [3:0]                stage_reg;
    logic [ROW_W-1:0]          row;
    logic signed [17:0]        cdiff;
    logic signed [17:0]        vdiff;
    logic signed [40:0]        cprod_reg;
    logic signed [42:0]        vprod_reg;
    logic signed [63:0]        pprod_reg;
    logic signed [31:0]        cur_reg;
    logic signed [31:0]        volt_reg;
    logic signed [31:0]        pwr_reg;

    assign row   = cal_row(battery_count);
    assign cdiff = $signed({2'b00, current_sense}) - $signed({4'b0000, CAL_OFFSET_ROM[row]});
    assign vdiff = $signed({2'b00, voltage_sense}) - 18'(voltage_offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cprod_reg <= cdiff * $signed({1'b0, CAL_GAIN_ROM[row]});
            vprod_reg <= vdiff * $signed({1'b0, voltage_scale});
        end
        if (stage_reg[0])
        begin
            cur_reg  <= sat32(shift_trunc(64'(cprod_reg), ADC_FRAC));
            volt_reg <= sat32(shift_trunc(64'(vprod_reg), ADC_FRAC));
        end
        if (stage_reg[1])
        begin
            pprod_reg <= cur_reg * volt_reg;
        end
        if (stage_reg[2])
        begin
            pwr_reg <= sat32(shift_trunc(pprod_reg, RESULT_FRAC));
        end
    end

    assign done    = stage_reg[3];
    assign current = cur_reg;
    assign voltage = volt_reg;
    assign power   = pwr_reg;

endmodule

`default_nettype wire

>>> rtl/core/bpra_divider.sv
`default_nettype none

// unsigned restoring divider, one quotient bit per cycle
module bpra_divider #(
    parameter int unsigned NW = 39,
    parameter int unsigned DW = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [NW-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvs_reg;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/battery_power_rolling_average_unit.sv
// Battery power rolling average.
// samples: one current and one voltage ADC reading (Q3.13) per transfer.
// results: latest current and voltage and the means of the voltage, current
//   and power histories (Q16.16), one transfer per sample.
// cfg: register writes (battery count, voltage offset, voltage scale, window
//   size), always ready; write only while no sample is in flight.
// Histories sit in one synchronous memory of HISTORY_DEPTH rows. A sample passes
// through calibration and power multiply, a history write, a read and sum of the
// L newest rows, then three divisions on one shared divider (skipped while the
// history is empty), and an output load.
// One sample is processed at a time; samples.ready is high only when idle.
// A finished result is held in the output register while the sink stalls;
// the next sample may be taken in the meantime, and its result waits until
// the held one has been transferred.
// Reset restores the register defaults and empties the histories; memory
// contents are not cleared since only rows written since reset are read.
`default_nettype none

module battery_power_rolling_average_unit #(
    parameter int unsigned HISTORY_DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bpra_in_if.sink     samples,
    bpra_out_if.source  results,
    bpra_cfg_if.sink    cfg
);
    import bpra_pkg::*;

    localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned LW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned CW = (LW > 7) ? LW + 1 : 8;
    localparam int unsigned SW = 32 + LW;

    state_t             state_reg, state_next;
    mean_sel_t          sel_reg;

    logic [3:0]         bat_cnt_reg;
    logic signed [15:0] volt_off_reg;
    logic [23:0]        volt_scale_reg;
    logic [6:0]         window_reg;

    logic [AW-1:0]      ptr_reg;
    logic [LW-1:0]      len_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [LW-1:0]      rd_cnt_reg;
    logic               rd_valid_reg;
    logic signed [SW-1:0] sum_v_reg, sum_c_reg, sum_p_reg;
    logic signed [31:0] mean_v_reg, mean_c_reg, mean_p_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_cur_reg, out_volt_reg, out_mv_reg, out_mc_reg, out_mp_reg;

    logic               accept;
    logic               cal_done;
    logic signed [31:0] cal_cur, cal_volt, cal_pwr;
    logic               mem_we;
    logic               rd_en;
    logic [95:0]        rd_data;
    logic               div_start;
    logic               div_done;
    logic [SW-1:0]      div_quo;
    logic signed [SW-1:0] sum_sel;
    logic [SW-1:0]      sum_mag;
    logic signed [31:0] mean_val;
    logic               out_load;
    logic [CW-1:0]      win;
    logic [CW-1:0]      len_inc;
    logic [LW-1:0]      len_new;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_cnt_reg    <= BATTERY_COUNT_RESET;
            volt_off_reg   <= '0;
            volt_scale_reg <= VOLTAGE_SCALE_RESET;
            window_reg     <= WINDOW_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BATTERY_COUNT:  bat_cnt_reg    <= cfg.data[3:0];
                REG_VOLTAGE_OFFSET: volt_off_reg   <= cfg.data[15:0];
                REG_VOLTAGE_SCALE:  volt_scale_reg <= cfg.data;
                REG_WINDOW_SIZE:    window_reg     <= cfg.data[6:0];
                default:            ;
            endcase
        end
    end

    // ---------------- datapath units ----------------
    assign accept = samples.valid && samples.ready;

    bpra_calib u_calib (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (accept),
        .current_sense  (samples.current_sense),
        .voltage_sense  (samples.voltage_sense),
        .battery_count  (bat_cnt_reg),
        .voltage_offset (volt_off_reg),
        .voltage_scale  (volt_scale_reg),
        .done           (cal_done),
        .current        (cal_cur),
        .voltage        (cal_volt),
        .power          (cal_pwr)
    );

    bpra_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW),
        .W     (96)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (ptr_reg),
        .wr_data ({cal_volt, cal_cur, cal_pwr}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (sel_reg)
            SEL_VOLTAGE: sum_sel = sum_v_reg;
            SEL_CURRENT: sum_sel = sum_c_reg;
            default:     sum_sel = sum_p_reg;
        endcase
    end

    assign sum_mag = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);

    bpra_divider #(
        .NW (SW),
        .DW (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // mean truncates toward zero: divide the magnitude, restore the sign
    always_comb
    begin
        if (len_reg == '0)
        begin
            mean_val = '0;
        end
        else if (sum_sel[SW-1])
        begin
            mean_val = -$signed(div_quo[31:0]);
        end
        else
        begin
            mean_val = $signed(div_quo[31:0]);
        end
    end

    // history length becomes min(length + 1, clamped window)
    assign win     = (CW'(window_reg) > CW'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH)
                                                             : CW'(window_reg);
    assign len_inc = CW'(len_reg) + CW'(1);
    assign len_new = (len_inc > win) ? win[LW-1:0] : len_inc[LW-1:0];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (cal_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (rd_cnt_reg == len_reg)
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (div_done || len_reg == '0)
                begin
                    state_next = (sel_reg == SEL_POWER) ? ST_OUT : ST_DIVGO;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        samples.ready = (state_reg == ST_IDLE);
        mem_we        = (state_reg == ST_WRITE);
        rd_en         = (state_reg == ST_SUM) && (rd_cnt_reg != len_reg);
        div_start     = (state_reg == ST_DIVGO) && (len_reg != '0);
        out_load      = (state_reg == ST_OUT) && (!out_valid_reg || results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            sel_reg       <= SEL_VOLTAGE;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (mem_we)
            begin
                ptr_reg <= (ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                len_reg <= len_new;
                sel_reg <= SEL_VOLTAGE;
            end
            if (state_reg == ST_DIVWAIT && (div_done || len_reg == '0))
            begin
                case (sel_reg)
                    SEL_VOLTAGE: sel_reg <= SEL_CURRENT;
                    SEL_CURRENT: sel_reg <= SEL_POWER;
                    default:     sel_reg <= SEL_VOLTAGE;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rd_addr_reg <= ptr_reg;
            rd_cnt_reg  <= '0;
            sum_v_reg   <= '0;
            sum_c_reg   <= '0;
            sum_p_reg   <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_addr_reg <= (rd_addr_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                                   : rd_addr_reg - 1'b1;
                rd_cnt_reg  <= rd_cnt_reg + 1'b1;
            end
            // read data of the row requested in the previous cycle
            if (rd_valid_reg)
            begin
                sum_v_reg <= sum_v_reg + SW'($signed(rd_data[95:64]));
                sum_c_reg <= sum_c_reg + SW'($signed(rd_data[63:32]));
                sum_p_reg <= sum_p_reg + SW'($signed(rd_data[31:0]));
            end
        end
        if (state_reg == ST_DIVWAIT && (div_done || len_reg == '0))
        begin
            case (sel_reg)
                SEL_VOLTAGE: mean_v_reg <= mean_val;
                SEL_CURRENT: mean_c_reg <= mean_val;
                default:     mean_p_reg <= mean_val;
            endcase
        end
        if (out_load)
        begin
            out_cur_reg  <= cal_cur;
            out_volt_reg <= cal_volt;
            out_mv_reg   <= mean_v_reg;
            out_mc_reg   <= mean_c_reg;
            out_mp_reg   <= mean_p_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.latest_current = out_cur_reg;
    assign results.latest_voltage = out_volt_reg;
    assign results.mean_voltage   = out_mv_reg;
    assign results.mean_current   = out_mc_reg;
    assign results.mean_power     = out_mp_reg;

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import bpra_pkg::*;

    localparam int unsigned HIST_DEPTH     = 64;
    localparam int unsigned RANDOM_ITEMS   = 1330;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_OFF       = 250;

    // current calibration: row four (also used for counts out of range) and the rest
    localparam longint ROW4_OFFSET = 13238;
    localparam longint STD_OFFSET  = 2650;
    localparam longint SENSE_GAIN  = 2482425;
    localparam longint I32_MAX     = 64'sd2147483647;
    localparam longint I32_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] latest_current;
        logic signed [31:0] latest_voltage;
        logic signed [31:0] mean_voltage;
        logic signed [31:0] mean_current;
        logic signed [31:0] mean_power;
    } power_report_t;

    typedef struct packed {
        logic          known;
        power_report_t report;
    } sample_tag_t;

    typedef enum logic {
        ROW_SETTING,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [3:0]         battery_count;
        logic signed [15:0] voltage_offset;
        logic [23:0]        voltage_scale;
        logic [6:0]         window;
        logic [15:0]        current_sense;
        logic [15:0]        voltage_sense;
        logic               known;
        power_report_t      report;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bpra_in_if  sample_bus ();
    bpra_out_if report_bus ();
    bpra_cfg_if cfg_bus ();

    battery_power_rolling_average_unit #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .results (report_bus),
        .cfg     (cfg_bus)
    );

    // predictor copy of the registers and histories
    logic [3:0]         m_battery_count  = 4'd4;
    logic signed [15:0] m_volt_ofs       = 16'sd0;
    logic [23:0]        m_volt_gain      = 24'd65536;
    logic [6:0]         m_window         = 7'd10;
    int                 volt_hist [HIST_DEPTH];
    int                 cur_hist [HIST_DEPTH];
    int                 pwr_hist [HIST_DEPTH];
    int unsigned        wr_slot  = 0;
    int unsigned        hist_len = 0;

    power_report_t expected_reports [$];
    sample_tag_t   sample_tags [$];
    stim_row_t     directed [$];

    int unsigned samples_taken    = 0;
    int unsigned reports_checked  = 0;
    int unsigned settings_applied = 0;
    int unsigned mismatches       = 0;
    int unsigned burst_left       = 0;

    function automatic longint trunc_shift(input longint v, input int unsigned s);
        if (v < 0)
        begin
            return -((-v) >> s);
        end
        return v >> s;
    endfunction

    function automatic int clamp32(input longint v);
        if (v > I32_MAX)
        begin
            return int'(I32_MAX);
        end
        if (v < I32_MIN)
        begin
            return int'(I32_MIN);
        end
        return int'(v);
    endfunction

    // calibrate one reading pair, push it into the histories and average them
    function automatic power_report_t predict_report(input logic [15:0] cs,
                                                    input logic [15:0] vs);
        power_report_t r;
        longint        cal_offset;
        longint        volt_sum;
        longint        cur_sum;
        longint        pwr_sum;
        int            cur;
        int            volt;
        int            pwr;
        int unsigned   win;
        int unsigned   slot;
        int unsigned   k;
        cal_offset = (m_battery_count == 4'd4 || m_battery_count == 4'd0 ||
                      m_battery_count > 4'd8) ? ROW4_OFFSET : STD_OFFSET;
        win = (m_window > HIST_DEPTH) ? HIST_DEPTH : m_window;
        cur = clamp32(trunc_shift((longint'(cs) - cal_offset) * SENSE_GAIN, 13));
        volt = clamp32(trunc_shift((longint'(vs) - longint'(m_volt_ofs)) *
                                   longint'(m_volt_gain), 13));
        pwr = clamp32(trunc_shift(longint'(volt) * longint'(cur), 16));
        volt_hist[wr_slot] = volt;
        cur_hist[wr_slot] = cur;
        pwr_hist[wr_slot] = pwr;
        wr_slot = (wr_slot + 1) % HIST_DEPTH;
        hist_len = (hist_len + 1 > win) ? win : hist_len + 1;
        volt_sum = 0;
        cur_sum = 0;
        pwr_sum = 0;
        for (k = 1; k <= hist_len; k++)
        begin
            slot = (wr_slot + HIST_DEPTH - k) % HIST_DEPTH;
            volt_sum += volt_hist[slot];
            cur_sum += cur_hist[slot];
            pwr_sum += pwr_hist[slot];
        end
        r.latest_current = cur;
        r.latest_voltage = volt;
        if (hist_len == 0)
        begin
            r.mean_voltage = '0;
            r.mean_current = '0;
            r.mean_power = '0;
        end
        else
        begin
            r.mean_voltage = int'(volt_sum / longint'(hist_len));
            r.mean_current = int'(cur_sum / longint'(hist_len));
            r.mean_power = int'(pwr_sum / longint'(hist_len));
        end
        return r;
    endfunction

    function automatic stim_row_t setting_row(input logic [3:0] bc,
                                              input logic signed [15:0] voff,
                                              input logic [23:0] vscale,
                                              input logic [6:0] win);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SETTING;
        row.battery_count = bc;
        row.voltage_offset = voff;
        row.voltage_scale = vscale;
        row.window = win;
        return row;
    endfunction

    function automatic stim_row_t sample_row(input logic [15:0] cs, input logic [15:0] vs,
                                             input logic known, input power_report_t report);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.current_sense = cs;
        row.voltage_sense = vs;
        row.known = known;
        row.report = report;
        return row;
    endfunction

    function automatic void add_row(input stim_row_t row);
        directed.insert(directed.size(), row);
    endfunction

    function automatic logic [15:0] pick_sense();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(ROW4_OFFSET + $urandom_range(0, 16) - 8);
            3: return 16'(STD_OFFSET + $urandom_range(0, 16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // sender side: bursts of back-to-back transfers separated by random gaps
    task automatic push_sample(input logic [15:0] cs, input logic [15:0] vs,
                               input logic known, input power_report_t report);
        int unsigned gap;
        sample_tag_t tag;
        tag.known = known;
        tag.report = report;
        sample_tags.insert(sample_tags.size(), tag);
        sample_bus.valid <= 1'b1;
        sample_bus.current_sense <= cs;
        sample_bus.voltage_sense <= vs;
        do @(posedge clk); while (!sample_bus.ready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // hold off new samples until every outstanding report has come back
    task automatic settle();
        sample_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_reports.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    task automatic set_config(input logic [3:0] bc, input logic signed [15:0] voff,
                              input logic [23:0] vscale, input logic [6:0] win);
        settle();
        write_reg(REG_BATTERY_COUNT, 24'(bc));
        write_reg(REG_VOLTAGE_OFFSET, {8'h00, voff});
        write_reg(REG_VOLTAGE_SCALE, vscale);
        write_reg(REG_WINDOW_SIZE, 24'(win));
        cfg_bus.valid <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: holds ready high or low for random stretches
    initial
    begin
        int unsigned hold_left;
        logic        accepting;
        hold_left = 0;
        report_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0)
            begin
                accepting = ($urandom_range(0, 3) != 0);
                hold_left = accepting ? $urandom_range(1, 60) : $urandom_range(1, 24);
                report_bus.ready <= accepting;
            end
            else
            begin
                hold_left--;
            end
        end
    end

    // every transfer on every channel is observed here at the clock edge
    always @(posedge clk)
    begin
        power_report_t predicted;
        power_report_t want;
        sample_tag_t   tag;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    REG_BATTERY_COUNT:  m_battery_count = cfg_bus.data[3:0];
                    REG_VOLTAGE_OFFSET: m_volt_ofs = cfg_bus.data[15:0];
                    REG_VOLTAGE_SCALE:  m_volt_gain = cfg_bus.data;
                    REG_WINDOW_SIZE:    m_window = cfg_bus.data[6:0];
                    default: ;
                endcase
            end
            if (sample_bus.valid && sample_bus.ready)
            begin
                predicted = predict_report(sample_bus.current_sense, sample_bus.voltage_sense);
                tag = (sample_tags.size() != 0) ? sample_tags.pop_front() : '0;
                expected_reports.insert(expected_reports.size(),
                                        tag.known ? tag.report : predicted);
                samples_taken++;
            end
            if (report_bus.valid && report_bus.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: report with nothing outstanding, got current %0d voltage %0d",
                             $time, report_bus.latest_current, report_bus.latest_voltage);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("latest_current", want.latest_current, report_bus.latest_current);
                    check_field("latest_voltage", want.latest_voltage, report_bus.latest_voltage);
                    check_field("mean_voltage", want.mean_voltage, report_bus.mean_voltage);
                    check_field("mean_current", want.mean_current, report_bus.mean_current);
                    check_field("mean_power", want.mean_power, report_bus.mean_power);
                    reports_checked++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on any channel
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_bus.valid && sample_bus.ready) ||
                (report_bus.valid && report_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("%0t: watchdog expired, %0d reports still outstanding",
                 $time, expected_reports.size());
        $display("battery_power_rolling_average_unit test failed");
        $finish;
    end

    initial
    begin
        int unsigned random_items;
        int unsigned phase_len;
        int unsigned n;
        logic [3:0]         bc;
        logic signed [15:0] voff;
        logic [23:0]        vscale;
        logic [6:0]         win;

        rst_n <= 1'b0;
        sample_bus.valid <= 1'b0;
        sample_bus.current_sense <= '0;
        sample_bus.voltage_sense <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_BATTERY_COUNT;
        cfg_bus.data <= '0;

        // reset defaults: row four, unit voltage scale, window of ten
        add_row(sample_row(16'd13238, 16'd0, 1'b1, '0));
        add_row(sample_row(16'd13238, 16'd8192, 1'b1,
                           '{32'sd0, 32'sd65536, 32'sd32768, 32'sd0, 32'sd0}));
        add_row(sample_row(16'd13238, 16'd16384, 1'b1,
                           '{32'sd0, 32'sd131072, 32'sd65536, 32'sd0, 32'sd0}));
        add_row(sample_row(16'd0, 16'd0, 1'b0, '0));
        add_row(sample_row(16'hFFFF, 16'hFFFF, 1'b0, '0));
        // count zero falls back to row four; full scale drives power into saturation
        add_row(setting_row(4'd0, -16'sd32768, 24'hFFFFFF, 7'd64));
        add_row(sample_row(16'hFFFF, 16'hFFFF, 1'b0, '0));
        add_row(sample_row(16'd13238, 16'd0, 1'b0, '0));
        // window above depth, negative voltage saturates power low
        add_row(setting_row(4'd15, 16'sd32767, 24'hFFFFFF, 7'd127));
        add_row(sample_row(16'hFFFF, 16'd0, 1'b0, '0));
        add_row(sample_row(16'd0, 16'hFFFF, 1'b0, '0));
        add_row(sample_row(16'd0, 16'd0, 1'b0, '0));
        // window zero: histories written but all means read zero
        add_row(setting_row(4'd1, 16'sd0, 24'd0, 7'd0));
        add_row(sample_row(16'd2650, 16'd1234, 1'b1, '0));
        add_row(sample_row(16'hFFFF, 16'hFFFF, 1'b0, '0));
        add_row(setting_row(4'd8, 16'sd8192, 24'd65536, 7'd64));
        add_row(sample_row(16'd30000, 16'd16384, 1'b0, '0));
        add_row(sample_row(16'd40000, 16'd24576, 1'b0, '0));
        add_row(sample_row(16'd2650, 16'd8192, 1'b0, '0));
        add_row(sample_row(16'hFFFF, 16'd0, 1'b0, '0));
        add_row(sample_row(16'd12345, 16'd54321, 1'b0, '0));
        add_row(sample_row(16'd50000, 16'd40000, 1'b0, '0));
        // shrink the window to two: only the newest entries count
        add_row(setting_row(4'd2, 16'sd8192, 24'd65536, 7'd2));
        add_row(sample_row(16'd20000, 16'd30000, 1'b0, '0));
        add_row(sample_row(16'd3000, 16'd60000, 1'b0, '0));
        add_row(setting_row(4'd9, -16'sd1, 24'd1, 7'd1));
        add_row(sample_row(16'd1, 16'd1, 1'b0, '0));
        add_row(sample_row(16'hFFFF, 16'h8000, 1'b0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_SETTING)
            begin
                set_config(directed[i].battery_count, directed[i].voltage_offset,
                           directed[i].voltage_scale, directed[i].window);
            end
            else
            begin
                push_sample(directed[i].current_sense, directed[i].voltage_sense,
                            directed[i].known, directed[i].report);
            end
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            bc = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
                0: voff = -16'sd32768;
                1: voff = 16'sd32767;
                2: voff = 16'sd0;
                default: voff = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: vscale = 24'd0;
                1: vscale = 24'hFFFFFF;
                2: vscale = 24'd65536;
                default: vscale = 24'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: win = 7'd0;
                1: win = 7'd1;
                2: win = 7'd64;
                3: win = 7'd127;
                4: win = 7'($urandom_range(65, 126));
                5: win = 7'($urandom_range(21, 63));
                default: win = 7'($urandom_range(2, 20));
            endcase
            set_config(bc, voff, vscale, win);
            phase_len = $urandom_range(10, 120);
            for (n = 0; n < phase_len && random_items < RANDOM_ITEMS; n++)
            begin
                push_sample(pick_sense(), pick_sense(), 1'b0, '0);
                random_items++;
                if ($urandom_range(0, 99) == 0)
                begin
                    settle();
                end
            end
        end

        settle();
        repeat (HOLD_OFF) @(posedge clk);

        $display("checked %0d reports from %0d samples across %0d register settings",
                 reports_checked, samples_taken, settings_applied);
        $display("covered window zero, one, full and above depth, all battery counts, saturation");
        if (mismatches == 0 && expected_reports.size() == 0)
        begin
            $display("battery_power_rolling_average_unit test passed");
        end
        else
        begin
            $display("battery_power_rolling_average_unit test failed");
        end
        $finish;
    end

endmodule
